// ===== hw/rtl/pulse_width_remote_code_sender_unit_defines.svh =====
// Assertion macros used by the pulse-width code sender core.
`ifndef PULSE_WIDTH_REMOTE_CODE_SENDER_UNIT_DEFINES_SVH
`define PULSE_WIDTH_REMOTE_CODE_SENDER_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define PWRCS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pwrcs assertion failed");

// Next-cycle implication, checked while out of reset.
`define PWRCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pwrcs assertion failed");

`endif

// ===== hw/rtl/pwrcs_pkg.sv =====
// Types and constants of the pulse-width remote code sender.
package pwrcs_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_ADDRESS   = 3'd0;
  localparam logic [2:0] REG_ZERO_LOW  = 3'd1;
  localparam logic [2:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [2:0] REG_ONE_LOW   = 3'd3;
  localparam logic [2:0] REG_ONE_HIGH  = 3'd4;
  localparam logic [2:0] REG_GAP       = 3'd5;
  localparam logic [2:0] REG_REPEAT    = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [31:0] ADDRESS_RST   = 32'd352136;
  localparam logic [15:0] ZERO_LOW_RST  = 16'd810;
  localparam logic [15:0] ZERO_HIGH_RST = 16'd240;
  localparam logic [15:0] ONE_LOW_RST   = 16'd280;
  localparam logic [15:0] ONE_HIGH_RST  = 16'd770;
  localparam logic [15:0] GAP_RST       = 16'd6000;
  localparam logic [7:0]  REPEAT_RST    = 8'd10;

  // Command codes and the bit patterns they send.
  localparam logic [7:0] CMD_ELEVEN = 8'd11;
  localparam logic [7:0] CMD_TEN    = 8'd10;
  localparam logic [7:0] CMD_TWELVE = 8'd12;
  localparam logic [5:0] PAT_ELEVEN = 6'b010000;
  localparam logic [5:0] PAT_TEN    = 6'b010100;
  localparam logic [5:0] PAT_TWELVE = 6'b011000;

  // Input operation codes.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LOW  = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [15:0] zero_low;
    logic [15:0] zero_high;
    logic [15:0] one_low;
    logic [15:0] one_high;
    logic [15:0] gap;
    logic [7:0]  repeat_cnt;
  } timing_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } result_t;

endpackage

// ===== hw/rtl/pwrcs_cfg_regs.sv =====
// Configuration register file of the pulse-width code sender.
module pwrcs_cfg_regs import pwrcs_pkg::*; #(
  parameter int ADDRESS_LENGTH = 19,
  parameter int CFG_W          = 19
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_wdata_i,
  output logic [ADDRESS_LENGTH-1:0] address_o,
  output timing_t                   timing_o
);

  logic [ADDRESS_LENGTH-1:0] address_q;
  timing_t                   timing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_q           <= ADDRESS_RST[ADDRESS_LENGTH-1:0];
      timing_q.zero_low   <= ZERO_LOW_RST;
      timing_q.zero_high  <= ZERO_HIGH_RST;
      timing_q.one_low    <= ONE_LOW_RST;
      timing_q.one_high   <= ONE_HIGH_RST;
      timing_q.gap        <= GAP_RST;
      timing_q.repeat_cnt <= REPEAT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ADDRESS:   address_q           <= cfg_wdata_i[ADDRESS_LENGTH-1:0];
        REG_ZERO_LOW:  timing_q.zero_low   <= cfg_wdata_i[15:0];
        REG_ZERO_HIGH: timing_q.zero_high  <= cfg_wdata_i[15:0];
        REG_ONE_LOW:   timing_q.one_low    <= cfg_wdata_i[15:0];
        REG_ONE_HIGH:  timing_q.one_high   <= cfg_wdata_i[15:0];
        REG_GAP:       timing_q.gap        <= cfg_wdata_i[15:0];
        REG_REPEAT:    timing_q.repeat_cnt <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign address_o = address_q;
  assign timing_o  = timing_q;

endmodule

// ===== hw/rtl/pwrcs_core.sv =====
// Symbol sequencer: phase, tick counter, symbol index and repeat counter.
`include "pulse_width_remote_code_sender_unit_defines.svh"

module pwrcs_core import pwrcs_pkg::*; #(
  parameter int ADDRESS_LENGTH = 19,
  parameter int COMMAND_LENGTH = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic                      operation_i,
  input  logic [7:0]                command_i,
  input  logic [ADDRESS_LENGTH-1:0] address_i,
  input  timing_t                   timing_i,
  output result_t                   result_o
);

  localparam int SYM_W = $clog2(ADDRESS_LENGTH + COMMAND_LENGTH + 1);
  localparam logic [SYM_W-1:0] ADDR_SYMS  = SYM_W'(ADDRESS_LENGTH);
  localparam logic [SYM_W-1:0] ALL_SYMS   = SYM_W'(ADDRESS_LENGTH + COMMAND_LENGTH);
  localparam logic [SYM_W-1:0] ADDR_LAST  = SYM_W'(ADDRESS_LENGTH - 1);
  localparam logic [SYM_W-1:0] ALL_LAST   = SYM_W'(ADDRESS_LENGTH + COMMAND_LENGTH - 1);

  phase_e                    phase_q, phase_d;
  logic [15:0]               tick_q, tick_d;
  logic [SYM_W-1:0]          sym_q, sym_d;
  logic [7:0]                rep_q, rep_d;
  logic [COMMAND_LENGTH-1:0] pat_q, pat_d;
  logic                      present_q, present_d;

  logic [SYM_W-1:0]          addr_sh, cmd_sh, sym_inc, sym_total;
  logic [ADDRESS_LENGTH-1:0] addr_shift;
  logic [COMMAND_LENGTH-1:0] cmd_shift;
  logic                      bit_one;
  logic [15:0]               part_len, len_eff;
  logic [16:0]               tick_inc;
  logic [15:0]               pat_wide;
  logic                      done;

  assign addr_sh    = ADDR_LAST - sym_q;
  assign cmd_sh     = ALL_LAST - sym_q;
  assign addr_shift = address_i >> addr_sh;
  assign cmd_shift  = pat_q >> cmd_sh;
  assign bit_one    = (sym_q < ADDR_SYMS) ? addr_shift[0] : cmd_shift[0];
  assign sym_inc    = sym_q + 1'b1;
  assign sym_total  = present_q ? ALL_SYMS : ADDR_SYMS;
  assign tick_inc   = {1'b0, tick_q} + 17'd1;

  always_comb begin
    case (phase_q)
      PH_LOW:  part_len = bit_one ? timing_i.one_low : timing_i.zero_low;
      PH_HIGH: part_len = bit_one ? timing_i.one_high : timing_i.zero_high;
      default: part_len = timing_i.gap;
    endcase
    len_eff = (part_len == 16'd0) ? 16'd1 : part_len;
  end

  always_comb begin
    case (command_i)
      CMD_ELEVEN: pat_wide = {10'd0, PAT_ELEVEN};
      CMD_TEN:    pat_wide = {10'd0, PAT_TEN};
      CMD_TWELVE: pat_wide = {10'd0, PAT_TWELVE};
      default:    pat_wide = 16'd0;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    sym_d     = sym_q;
    rep_d     = rep_q;
    pat_d     = pat_q;
    present_d = present_q;
    done      = 1'b0;
    if (accept_i) begin
      if (operation_i == OP_START) begin
        if (phase_q == PH_IDLE) begin
          present_d = (command_i == CMD_ELEVEN) || (command_i == CMD_TEN) ||
                      (command_i == CMD_TWELVE);
          pat_d     = pat_wide[COMMAND_LENGTH-1:0];
          rep_d     = (timing_i.repeat_cnt == 8'd0) ? 8'd1 : timing_i.repeat_cnt;
          sym_d     = '0;
          tick_d    = 16'd0;
          phase_d   = PH_LOW;
        end
      end else if (phase_q != PH_IDLE) begin
        tick_d = tick_inc[15:0];
        if (tick_inc >= {1'b0, len_eff}) begin
          tick_d = 16'd0;
          case (phase_q)
            PH_LOW: phase_d = PH_HIGH;
            PH_HIGH: begin
              sym_d   = sym_inc;
              phase_d = (sym_inc >= sym_total) ? PH_GAP : PH_LOW;
            end
            PH_GAP: begin
              sym_d = '0;
              rep_d = rep_q - 8'd1;
              if (rep_q == 8'd1) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end else begin
                phase_d = PH_LOW;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tick_q    <= 16'd0;
      sym_q     <= '0;
      rep_q     <= 8'd0;
      pat_q     <= '0;
      present_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      sym_q     <= sym_d;
      rep_q     <= rep_d;
      pat_q     <= pat_d;
      present_q <= present_d;
    end
  end

  assign result_o.line_level = (phase_d == PH_HIGH);
  assign result_o.busy_res   = (phase_d != PH_IDLE);
  assign result_o.frame_done = done;

  // A transmission in progress always has at least one frame left to send.
  `PWRCS_ASSERT_IMPL(a_rep_nonzero, clk_i, rst_ni, phase_q != PH_IDLE, rep_q != 8'd0)
  // While a symbol is on the line its index lies inside the frame.
  `PWRCS_ASSERT_IMPL(a_sym_range, clk_i, rst_ni,
                     phase_q == PH_LOW || phase_q == PH_HIGH, sym_q < sym_total)
  // Ending the last frame returns to idle.
  `PWRCS_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done, phase_q == PH_IDLE)
  // A start taken while idle begins the first symbol with a cleared counter.
  `PWRCS_ASSERT_NEXT(a_start, clk_i, rst_ni,
                     accept_i && operation_i == OP_START && phase_q == PH_IDLE,
                     phase_q == PH_LOW && tick_q == 16'd0 && sym_q == '0)

endmodule

// ===== hw/rtl/pwrcs_out_buf.sv =====
// Two-entry result buffer that decouples the output stall from input acceptance.
module pwrcs_out_buf import pwrcs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t data_o
);

  result_t     entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;
  logic        pop;

  assign pop = (count_q != 2'd0) && !out_stall_i;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign data_o      = entry_q[rd_ptr_q];

endmodule

// ===== hw/rtl/pulse_width_remote_code_sender_unit.sv =====
// Top level of the pulse-width remote code sender.
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o   operation_i, command_i
//  out      output     out_valid_o / out_stall_i line_level_o, busy_res_o, frame_done_o
//  cfg      input      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// Each transaction is processed in the cycle it is accepted; its result is registered
// in the result buffer. One transaction per cycle is sustained while the output is not stalled.
// The result buffer holds two entries; the input stalls only when both are full.
// Reset is asynchronous and active low and leaves the sender idle.
module pulse_width_remote_code_sender_unit import pwrcs_pkg::*; #(
  parameter int ADDRESS_LENGTH = 19,
  parameter int COMMAND_LENGTH = 6,
  localparam int CFG_W         = (ADDRESS_LENGTH > 16) ? ADDRESS_LENGTH : 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             operation_i,
  input  logic [7:0]       command_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             line_level_o,
  output logic             busy_res_o,
  output logic             frame_done_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  logic [ADDRESS_LENGTH-1:0] address;
  timing_t                   timing;
  result_t                   core_res, out_res;
  logic                      accept, buf_full;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  pwrcs_cfg_regs #(
    .ADDRESS_LENGTH(ADDRESS_LENGTH),
    .CFG_W         (CFG_W)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .address_o  (address),
    .timing_o   (timing)
  );

  pwrcs_core #(
    .ADDRESS_LENGTH(ADDRESS_LENGTH),
    .COMMAND_LENGTH(COMMAND_LENGTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .operation_i(operation_i),
    .command_i  (command_i),
    .address_i  (address),
    .timing_i   (timing),
    .result_o   (core_res)
  );

  pwrcs_out_buf u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .data_i     (core_res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .data_o     (out_res)
  );

  assign line_level_o = out_res.line_level;
  assign busy_res_o   = out_res.busy_res;
  assign frame_done_o = out_res.frame_done;

endmodule

// ===== bench/pulse_width_remote_code_sender_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the pulse-width remote code sender, with a cycle-level predictor.
module pulse_width_remote_code_sender_unit_test import pwrcs_pkg::*; ();

  localparam int ADDR_LEN = 19;
  localparam int CMD_LEN = 6;
  localparam int CFG_W = 19;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic       op;
    logic [7:0] cmd;
  } code_item_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             operation_i = OP_TICK;
  logic [7:0]       command_i = 8'h00;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             line_level_o;
  logic             busy_res_o;
  logic             frame_done_o;
  logic             cfg_we_i = 1'b0;
  logic [2:0]       cfg_index_i = REG_ADDRESS;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  // Items waiting to be sent and results the sender still owes.
  code_item_t pending_items_q[$];
  result_t    pin_results_q[$];

  logic in_took = 1'b0;
  int   src_pct = 0;
  int   sink_pct = 0;
  int   src_hold = 0;
  int   sink_hold = 0;

  int items_taken = 0;
  int results_checked = 0;
  int transmissions_done = 0;
  int mismatch_count = 0;

  // Predicted sender state and register copies.
  phase_e              tx_phase;
  logic [15:0]         tx_ticks;
  logic [4:0]          tx_symbol;
  logic [7:0]          tx_repeats;
  logic [5:0]          tx_pattern;
  logic                tx_has_cmd;
  logic [ADDR_LEN-1:0] reg_address;
  logic [15:0]         reg_zero_low;
  logic [15:0]         reg_zero_high;
  logic [15:0]         reg_one_low;
  logic [15:0]         reg_one_high;
  logic [15:0]         reg_gap;
  logic [7:0]          reg_repeat;
  result_t             want;

  pulse_width_remote_code_sender_unit i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .command_i,
    .out_valid_o,
    .out_stall_i,
    .line_level_o,
    .busy_res_o,
    .frame_done_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic result_t step_sender(input logic op, input logic [7:0] cmd);
    logic [15:0] span;
    logic        bit_one;
    result_t     res;
    res.frame_done = 1'b0;
    if (op == OP_START) begin
      if (tx_phase == PH_IDLE) begin
        tx_has_cmd = 1'b1;
        case (cmd)
          CMD_ELEVEN: tx_pattern = PAT_ELEVEN;
          CMD_TEN: tx_pattern = PAT_TEN;
          CMD_TWELVE: tx_pattern = PAT_TWELVE;
          default: begin
            tx_pattern = '0;
            tx_has_cmd = 1'b0;
          end
        endcase
        tx_repeats = (reg_repeat == 8'd0) ? 8'd1 : reg_repeat;
        tx_symbol = '0;
        tx_ticks = '0;
        tx_phase = PH_LOW;
      end
    end else if (tx_phase != PH_IDLE) begin
      tx_ticks = tx_ticks + 16'd1;
      bit_one = 1'b0;
      if (tx_phase != PH_GAP) begin
        if (tx_symbol < ADDR_LEN) bit_one = reg_address[ADDR_LEN - 1 - tx_symbol];
        else bit_one = tx_pattern[CMD_LEN - 1 - (tx_symbol - ADDR_LEN)];
      end
      case (tx_phase)
        PH_LOW: span = bit_one ? reg_one_low : reg_zero_low;
        PH_HIGH: span = bit_one ? reg_one_high : reg_zero_high;
        default: span = reg_gap;
      endcase
      // A zero length still lasts one tick.
      if (span == 16'd0) span = 16'd1;
      if (tx_ticks >= span) begin
        tx_ticks = '0;
        case (tx_phase)
          PH_LOW: tx_phase = PH_HIGH;
          PH_HIGH: begin
            tx_symbol = tx_symbol + 5'd1;
            if (tx_symbol >= (tx_has_cmd ? ADDR_LEN + CMD_LEN : ADDR_LEN)) tx_phase = PH_GAP;
            else tx_phase = PH_LOW;
          end
          default: begin
            tx_symbol = '0;
            tx_repeats = tx_repeats - 8'd1;
            if (tx_repeats == 8'd0) begin
              tx_phase = PH_IDLE;
              res.frame_done = 1'b1;
            end else begin
              tx_phase = PH_LOW;
            end
          end
        endcase
      end
    end
    res.line_level = (tx_phase == PH_HIGH);
    res.busy_res = (tx_phase != PH_IDLE);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Register copies, result checking and prediction, all at the sampling edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ADDRESS: reg_address = cfg_wdata_i[ADDR_LEN-1:0];
          REG_ZERO_LOW: reg_zero_low = cfg_wdata_i[15:0];
          REG_ZERO_HIGH: reg_zero_high = cfg_wdata_i[15:0];
          REG_ONE_LOW: reg_one_low = cfg_wdata_i[15:0];
          REG_ONE_HIGH: reg_one_high = cfg_wdata_i[15:0];
          REG_GAP: reg_gap = cfg_wdata_i[15:0];
          REG_REPEAT: reg_repeat = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (pin_results_q.size() == 0) begin
          report_mismatch("result transaction with no expected result");
        end else begin
          want = pin_results_q.pop_front();
          results_checked++;
          if (want.frame_done) transmissions_done++;
          if (line_level_o !== want.line_level)
            report_mismatch($sformatf("line_level %0b, expected %0b",
                                      line_level_o, want.line_level));
          if (busy_res_o !== want.busy_res)
            report_mismatch($sformatf("busy_res %0b, expected %0b", busy_res_o, want.busy_res));
          if (frame_done_o !== want.frame_done)
            report_mismatch($sformatf("frame_done %0b, expected %0b",
                                      frame_done_o, want.frame_done));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pin_results_q.push_back(step_sender(operation_i, command_i));
        items_taken++;
      end
      in_took <= in_valid_i && !in_stall_o;
    end
  end

  // Input driver: holds each transaction until it is taken, with random idle bursts.
  always @(negedge clk_i) begin
    if (in_took) void'(pending_items_q.pop_front());
    if (!in_valid_i || in_took) begin
      if (src_hold > 0) begin
        src_hold--;
        in_valid_i <= 1'b0;
      end else if (pending_items_q.size() != 0 && src_pct > 0 &&
                   $urandom_range(0, 99) < src_pct) begin
        src_hold = $urandom_range(0, 9);
        in_valid_i <= 1'b0;
      end else if (pending_items_q.size() != 0) begin
        in_valid_i <= 1'b1;
        operation_i <= pending_items_q[0].op;
        command_i <= pending_items_q[0].cmd;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side stalls in random bursts.
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_stall_i <= 1'b1;
    end else if (sink_pct > 0 && $urandom_range(0, 99) < sink_pct) begin
      sink_hold = $urandom_range(0, 9);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic push_item(input logic op, input logic [7:0] cmd);
    code_item_t it;
    it.op = op;
    it.cmd = cmd;
    pending_items_q.push_back(it);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_timing(input logic [CFG_W-1:0] addr, input logic [CFG_W-1:0] zl,
                             input logic [CFG_W-1:0] zh, input logic [CFG_W-1:0] ol,
                             input logic [CFG_W-1:0] oh, input logic [CFG_W-1:0] gap,
                             input logic [CFG_W-1:0] rep);
    write_reg(REG_ADDRESS, addr);
    write_reg(REG_ZERO_LOW, zl);
    write_reg(REG_ZERO_HIGH, zh);
    write_reg(REG_ONE_LOW, ol);
    write_reg(REG_ONE_HIGH, oh);
    write_reg(REG_GAP, gap);
    write_reg(REG_REPEAT, rep);
  endtask

  // Feeds ticks until the predicted sender goes idle and every item is taken.
  task automatic run_out_transmission();
    while (tx_phase != PH_IDLE || pending_items_q.size() != 0 || in_valid_i) begin
      if (tx_phase != PH_IDLE && pending_items_q.size() < 2)
        push_item(OP_TICK, 8'($urandom_range(0, 255)));
      @(negedge clk_i);
    end
  endtask

  task automatic settle();
    while (pending_items_q.size() != 0 || in_valid_i || pin_results_q.size() != 0)
      @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  initial begin
    logic [7:0] cmd;
    reg_address = ADDRESS_RST[ADDR_LEN-1:0];
    reg_zero_low = ZERO_LOW_RST;
    reg_zero_high = ZERO_HIGH_RST;
    reg_one_low = ONE_LOW_RST;
    reg_one_high = ONE_HIGH_RST;
    reg_gap = GAP_RST;
    reg_repeat = REPEAT_RST;
    tx_phase = PH_IDLE;
    tx_ticks = '0;
    tx_symbol = '0;
    tx_repeats = '0;
    tx_pattern = '0;
    tx_has_cmd = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset timings: idle ticks, a start with an unmapped code and a start while busy.
    // Part of the first symbol goes by before the lengths drop to one tick.
    src_pct = 10;
    sink_pct = 10;
    write_reg(REG_REPEAT, 19'd1);
    push_item(OP_TICK, 8'hFF);
    push_item(OP_TICK, 8'h00);
    push_item(OP_START, 8'd200);
    push_item(OP_START, CMD_ELEVEN);
    repeat (20) push_item(OP_TICK, 8'h5A);
    settle();
    load_timing(ADDRESS_RST[ADDR_LEN-1:0], 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd1);
    run_out_transmission();
    settle();

    // All lengths and the repeat count at zero, which count as one.
    src_pct = 25;
    sink_pct = 25;
    load_timing(19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0);
    push_item(OP_START, CMD_ELEVEN);
    repeat (3) push_item(OP_TICK, 8'h00);
    push_item(OP_START, CMD_TEN);
    run_out_transmission();
    settle();

    // Distinct short lengths, two frames for the first start and one for the second, no idling at all.
    src_pct = 0;
    sink_pct = 0;
    load_timing(19'h55555, 19'd1, 19'd2, 19'd3, 19'd4, 19'd5, 19'd2);
    write_reg(REG_UNUSED, 19'h7FFFF);
    push_item(OP_START, CMD_TEN);
    run_out_transmission();
    write_reg(REG_REPEAT, 19'd1);
    push_item(OP_START, CMD_TWELVE);
    run_out_transmission();
    settle();

    // Top lengths: part of the first symbol goes by, then the lengths drop to one tick.
    src_pct = 10;
    sink_pct = 10;
    load_timing(19'h7FFFF, 19'hFFFF, 19'hFFFF, 19'hFFFF, 19'hFFFF, 19'hFFFF, 19'd1);
    push_item(OP_START, 8'd0);
    repeat (40) push_item(OP_TICK, 8'h00);
    settle();
    load_timing(19'h7FFFF, 19'd1, 19'd1, 19'd1, 19'd1, 19'd1, 19'd1);
    run_out_transmission();
    settle();

    // Random settings; unused upper data bits carry junk. The last phase runs without idling.
    for (int ph = 0; ph < 2; ph++) begin
      if (ph == 1) begin
        src_pct = 0;
        sink_pct = 0;
      end else begin
        src_pct = 5 * $urandom_range(0, 6);
        sink_pct = 5 * $urandom_range(0, 6);
      end
      load_timing(19'($urandom),
                  {3'($urandom), 16'($urandom_range(0, 2))},
                  {3'($urandom), 16'($urandom_range(0, 2))},
                  {3'($urandom), 16'($urandom_range(0, 2))},
                  {3'($urandom), 16'($urandom_range(0, 2))},
                  {3'($urandom), 16'($urandom_range(0, 3))},
                  {11'($urandom), 8'($urandom_range(0, 2))});
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(0, 14) == 0) begin
          case ($urandom_range(0, 3))
            0: cmd = CMD_ELEVEN;
            1: cmd = CMD_TEN;
            2: cmd = CMD_TWELVE;
            default: cmd = 8'($urandom_range(0, 255));
          endcase
          push_item(OP_START, cmd);
        end else begin
          push_item(OP_TICK, 8'($urandom_range(0, 255)));
        end
      end
      run_out_transmission();
      settle();
    end

    if (pin_results_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pin_results_q.size()));
    $display("Run covered %0d input transactions and %0d checked results, %0d transmissions ended.",
             items_taken, results_checked, transmissions_done);
    $display("Settings included reset values, zero and top lengths, lengths changed mid-frame.");
    if (mismatch_count == 0) begin
      $display("PASS pulse_width_remote_code_sender_unit");
    end else begin
      $display("FAIL pulse_width_remote_code_sender_unit");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAIL pulse_width_remote_code_sender_unit");
    $finish;
  end

endmodule
